// File: rtl/scrc_pkg.sv
// Shared types, widths and reset values for the screen-to-frame rectangle clip block.
package scrc_pkg;

   localparam int COORD_BITS        = 14;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int COEF_BITS         = 32;
   localparam int SIZE_BITS         = COORD_BITS + 1;
   localparam int CPT_BITS          = COORD_BITS + 3;
   localparam int PROD_BITS         = COEF_BITS + CPT_BITS;
   localparam int SUM_BITS          = PROD_BITS + 2;
   localparam int BND_BITS          = COORD_BITS + 3;
   localparam int CSR_ADDR_BITS     = 3;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_COEF_A       = 3'd0,
      CSR_COEF_B       = 3'd1,
      CSR_COEF_C       = 3'd2,
      CSR_COEF_D       = 3'd3,
      CSR_OFFSET_X     = 3'd4,
      CSR_OFFSET_Y     = 3'd5,
      CSR_FRAME_WIDTH  = 3'd6,
      CSR_FRAME_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] rect_x;
      logic [COORD_BITS-1:0] rect_y;
      logic [SIZE_BITS-1:0]  rect_w;
      logic [SIZE_BITS-1:0]  rect_h;
   } req_type;

   typedef struct packed {
      logic                  visible;
      logic [COORD_BITS-1:0] out_x;
      logic [COORD_BITS-1:0] out_y;
      logic [SIZE_BITS-1:0]  out_width;
      logic [SIZE_BITS-1:0]  out_height;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] coef_a;
      logic signed [COEF_BITS-1:0] coef_b;
      logic signed [COEF_BITS-1:0] coef_c;
      logic signed [COEF_BITS-1:0] coef_d;
      logic signed [COEF_BITS-1:0] offset_x;
      logic signed [COEF_BITS-1:0] offset_y;
      logic [SIZE_BITS-1:0]        frame_width;
      logic [SIZE_BITS-1:0]        frame_height;
   } cfg_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] px0;
      logic signed [SUM_BITS-1:0] px1;
      logic signed [SUM_BITS-1:0] py0;
      logic signed [SUM_BITS-1:0] py1;
   } sum_type;

   typedef struct packed {
      logic signed [BND_BITS-1:0] xlo;
      logic signed [BND_BITS-1:0] xhi;
      logic signed [BND_BITS-1:0] ylo;
      logic signed [BND_BITS-1:0] yhi;
   } bound_type;

   localparam cfg_type CFG_RESET = '{
      coef_a:       32'sd65536,
      coef_b:       32'sd0,
      coef_c:       32'sd0,
      coef_d:       32'sd65536,
      offset_x:     32'sd0,
      offset_y:     32'sd0,
      frame_width:  15'd1920,
      frame_height: 15'd1080
   };

endpackage

// File: rtl/scrc_xform.sv
// Corner expansion and affine transform: corners, products, sums (three register stages).
module scrc_xform (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  scrc_pkg::req_type   in_rect,
   input  scrc_pkg::cfg_type   cfg,
   output logic                out_valid,
   output scrc_pkg::sum_type   out_sum
);
   import scrc_pkg::*;

   // stage 1: grown corners
   logic                       s1_valid_ff;
   logic signed [CPT_BITS-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [CPT_BITS-1:0] rx_in, ry_in, rw_in, rh_in;
   logic signed [CPT_BITS-1:0] x0_in, y0_in, x1_in, y1_in;

   // stage 2: products
   logic                        s2_valid_ff;
   logic signed [PROD_BITS-1:0] ax0_ff, cy0_ff, bx0_ff, dy0_ff;
   logic signed [PROD_BITS-1:0] ax1_ff, cy1_ff, bx1_ff, dy1_ff;

   // stage 3: sums
   logic    s3_valid_ff;
   sum_type sum_ff;
   sum_type sum_in;

   always_comb begin
      rx_in = $signed({3'b000, in_rect.rect_x});
      ry_in = $signed({3'b000, in_rect.rect_y});
      rw_in = $signed({2'b00, in_rect.rect_w});
      rh_in = $signed({2'b00, in_rect.rect_h});
      x0_in = rx_in - CPT_BITS'(1);
      y0_in = ry_in - CPT_BITS'(1);
      x1_in = rx_in + rw_in + CPT_BITS'(1);
      y1_in = ry_in + rh_in + CPT_BITS'(1);
   end

   always_comb begin
      sum_in.px0 = SUM_BITS'(ax0_ff) + SUM_BITS'(cy0_ff) + SUM_BITS'(cfg.offset_x);
      sum_in.py0 = SUM_BITS'(bx0_ff) + SUM_BITS'(dy0_ff) + SUM_BITS'(cfg.offset_y);
      sum_in.px1 = SUM_BITS'(ax1_ff) + SUM_BITS'(cy1_ff) + SUM_BITS'(cfg.offset_x);
      sum_in.py1 = SUM_BITS'(bx1_ff) + SUM_BITS'(dy1_ff) + SUM_BITS'(cfg.offset_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff  <= x0_in;
      y0_ff  <= y0_in;
      x1_ff  <= x1_in;
      y1_ff  <= y1_in;
      ax0_ff <= cfg.coef_a * x0_ff;
      cy0_ff <= cfg.coef_c * y0_ff;
      bx0_ff <= cfg.coef_b * x0_ff;
      dy0_ff <= cfg.coef_d * y0_ff;
      ax1_ff <= cfg.coef_a * x1_ff;
      cy1_ff <= cfg.coef_c * y1_ff;
      bx1_ff <= cfg.coef_b * x1_ff;
      dy1_ff <= cfg.coef_d * y1_ff;
      sum_ff <= sum_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_sum   = sum_ff;

endmodule

// File: rtl/scrc_bound.sv
// Per-axis sort, floor/ceiling to integer pixels and bound saturation (two register stages).
module scrc_bound #(
   parameter int FRAC_BITS = scrc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  scrc_pkg::sum_type   in_sum,
   output logic                out_valid,
   output scrc_pkg::bound_type out_bound
);
   import scrc_pkg::*;

   localparam logic signed [SUM_BITS:0] ROUND   = (SUM_BITS+1)'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic signed [SUM_BITS:0] LIM     = (SUM_BITS+1)'(64'd1 << (COORD_BITS + 1));
   localparam logic signed [SUM_BITS:0] NEG_LIM = -LIM;

   function automatic logic signed [BND_BITS-1:0] sat_bound(input logic signed [SUM_BITS:0] v);
      logic signed [BND_BITS-1:0] r;
      if (v > LIM) begin
         r = BND_BITS'(LIM);
      end else if (v < NEG_LIM) begin
         r = BND_BITS'(NEG_LIM);
      end else begin
         r = BND_BITS'(v);
      end
      return r;
   endfunction

   // stage 4: sorted corners
   logic                       s4_valid_ff;
   logic signed [SUM_BITS-1:0] xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   logic signed [SUM_BITS-1:0] xmin_in, xmax_in, ymin_in, ymax_in;

   // stage 5: integer bounds
   logic                     s5_valid_ff;
   bound_type                bound_ff;
   bound_type                bound_in;
   logic signed [SUM_BITS:0] xmin_w, xmax_w, ymin_w, ymax_w;

   always_comb begin
      xmin_in = (in_sum.px0 < in_sum.px1) ? in_sum.px0 : in_sum.px1;
      xmax_in = (in_sum.px0 > in_sum.px1) ? in_sum.px0 : in_sum.px1;
      ymin_in = (in_sum.py0 < in_sum.py1) ? in_sum.py0 : in_sum.py1;
      ymax_in = (in_sum.py0 > in_sum.py1) ? in_sum.py0 : in_sum.py1;
   end

   always_comb begin
      xmin_w = (SUM_BITS+1)'(xmin_ff);
      xmax_w = (SUM_BITS+1)'(xmax_ff);
      ymin_w = (SUM_BITS+1)'(ymin_ff);
      ymax_w = (SUM_BITS+1)'(ymax_ff);
      bound_in.xlo = sat_bound(xmin_w >>> FRAC_BITS);
      bound_in.ylo = sat_bound(ymin_w >>> FRAC_BITS);
      bound_in.xhi = sat_bound((xmax_w + ROUND) >>> FRAC_BITS);
      bound_in.yhi = sat_bound((ymax_w + ROUND) >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= in_valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      xmin_ff  <= xmin_in;
      xmax_ff  <= xmax_in;
      ymin_ff  <= ymin_in;
      ymax_ff  <= ymax_in;
      bound_ff <= bound_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_bound = bound_ff;

   assert property (@(posedge clock) disable iff (reset)
      s5_valid_ff |-> (bound_ff.xlo <= bound_ff.xhi) && (bound_ff.ylo <= bound_ff.yhi))
      else $error("bounds out of order");

endmodule

// File: rtl/scrc_clip.sv
// Frame reject test and clip to the frame, output register.
module scrc_clip (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  scrc_pkg::bound_type            in_bound,
   input  logic [scrc_pkg::SIZE_BITS-1:0] frame_width,
   input  logic [scrc_pkg::SIZE_BITS-1:0] frame_height,
   output logic                           out_valid,
   output scrc_pkg::rsp_type              out_rsp
);
   import scrc_pkg::*;

   localparam logic [SIZE_BITS-1:0] FRAME_MAX = SIZE_BITS'(1 << COORD_BITS);

   logic [SIZE_BITS-1:0]       fw, fh;
   logic signed [BND_BITS-1:0] fw_s, fh_s;
   logic signed [BND_BITS-1:0] ox, oy, xr, yb, ow, oh;
   logic                       reject;

   logic    valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   always_comb begin
      fw     = (frame_width  > FRAME_MAX) ? FRAME_MAX : frame_width;
      fh     = (frame_height > FRAME_MAX) ? FRAME_MAX : frame_height;
      fw_s   = $signed({2'b00, fw});
      fh_s   = $signed({2'b00, fh});
      reject = (fw == '0) || (fh == '0) ||
               (in_bound.xhi < 0) || (in_bound.yhi < 0) ||
               (in_bound.xlo >= fw_s) || (in_bound.ylo >= fh_s);
      ox     = (in_bound.xlo > 0) ? in_bound.xlo : '0;
      oy     = (in_bound.ylo > 0) ? in_bound.ylo : '0;
      xr     = (in_bound.xhi < fw_s) ? in_bound.xhi : fw_s;
      yb     = (in_bound.yhi < fh_s) ? in_bound.yhi : fh_s;
      ow     = xr - ox;
      oh     = yb - oy;
      if (reject) begin
         rsp_in = '0;
      end else begin
         rsp_in.visible    = 1'b1;
         rsp_in.out_x      = ox[COORD_BITS-1:0];
         rsp_in.out_y      = oy[COORD_BITS-1:0];
         rsp_in.out_width  = ow[SIZE_BITS-1:0];
         rsp_in.out_height = oh[SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ff.visible) |->
         (rsp_ff.out_x == '0) && (rsp_ff.out_y == '0) &&
         (rsp_ff.out_width == '0) && (rsp_ff.out_height == '0))
      else $error("rejected box with nonzero fields");

endmodule

// File: rtl/screen_rect_to_frame_clip_core.sv
// Top level: configuration registers and the six-stage rectangle transform and clip pipeline.
//
//  channel  ports                               handshake
//  request  start, busy, req_data               taken when start && !busy
//  result   rsp_valid, rsp_data                 one-cycle strobe, no back-pressure
//  config   csr_we, csr_addr, csr_wdata         written when csr_we
//
// One request per cycle; each result passes through the six register stages in order:
// corners, products, sums, sort, floor/ceiling, clip.
// busy is never raised and nothing stalls.
// Synchronous reset clears the valid bits and loads the register defaults.
module screen_rect_to_frame_clip_core #(
   parameter int FRAC_BITS = scrc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  scrc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   output scrc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [scrc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [scrc_pkg::COEF_BITS-1:0]     csr_wdata
);
   import scrc_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      accept;
   logic      sum_valid, bound_valid;
   sum_type   sum_data;
   bound_type bound_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_COEF_A:       cfg_in.coef_a       = csr_wdata;
            CSR_COEF_B:       cfg_in.coef_b       = csr_wdata;
            CSR_COEF_C:       cfg_in.coef_c       = csr_wdata;
            CSR_COEF_D:       cfg_in.coef_d       = csr_wdata;
            CSR_OFFSET_X:     cfg_in.offset_x     = csr_wdata;
            CSR_OFFSET_Y:     cfg_in.offset_y     = csr_wdata;
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[SIZE_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   scrc_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_rect   (req_data),
      .cfg       (cfg_ff),
      .out_valid (sum_valid),
      .out_sum   (sum_data)
   );

   scrc_bound #(
      .FRAC_BITS (FRAC_BITS)
   ) u_bound (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_sum    (sum_data),
      .out_valid (bound_valid),
      .out_bound (bound_data)
   );

   scrc_clip u_clip (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (bound_valid),
      .in_bound     (bound_data),
      .frame_width  (cfg_ff.frame_width),
      .frame_height (cfg_ff.frame_height),
      .out_valid    (rsp_valid),
      .out_rsp      (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result without a request six cycles earlier");

endmodule

// File: test/screen_rect_to_frame_clip_core_tb.sv
// Testbench for screen_rect_to_frame_clip_core: directed and random rectangles checked by a scoreboard.
`timescale 1ns / 1ps

module screen_rect_to_frame_clip_core_tb;
   import scrc_pkg::*;

   localparam int    WATCHDOG_LIMIT = 2000;
   localparam int    FRAC           = FRAC_BITS_DEFAULT;
   localparam longint BOUND_LIM     = longint'(1) << (COORD_BITS + 1);
   localparam longint FRAME_LIM     = longint'(1) << COORD_BITS;

   class clip_scoreboard;
      cfg_type     cfg;
      rsp_type     expected_boxes[$];
      int unsigned mismatch_count;

      function new();
         cfg = CFG_RESET;
         mismatch_count = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [COEF_BITS-1:0] v);
         case (idx)
            CSR_COEF_A:       cfg.coef_a = v;
            CSR_COEF_B:       cfg.coef_b = v;
            CSR_COEF_C:       cfg.coef_c = v;
            CSR_COEF_D:       cfg.coef_d = v;
            CSR_OFFSET_X:     cfg.offset_x = v;
            CSR_OFFSET_Y:     cfg.offset_y = v;
            CSR_FRAME_WIDTH:  cfg.frame_width = v[SIZE_BITS-1:0];
            CSR_FRAME_HEIGHT: cfg.frame_height = v[SIZE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function longint floor_q(longint v);
         return v >>> FRAC;
      endfunction

      function longint ceil_q(longint v);
         return -floor_q(-v);
      endfunction

      function longint bound_sat(longint v);
         if (v > BOUND_LIM) return BOUND_LIM;
         if (v < -BOUND_LIM) return -BOUND_LIM;
         return v;
      endfunction

      function rsp_type clip_box(req_type r);
         longint a, b, c, d, e, f;
         longint x0, y0, x1, y1, px0, px1, py0, py1;
         longint xlo, xhi, ylo, yhi, fw, fh, ox, oy, ow, oh;
         rsp_type res;
         a = $signed(cfg.coef_a);
         b = $signed(cfg.coef_b);
         c = $signed(cfg.coef_c);
         d = $signed(cfg.coef_d);
         e = $signed(cfg.offset_x);
         f = $signed(cfg.offset_y);
         x0 = longint'(r.rect_x) - 1;
         y0 = longint'(r.rect_y) - 1;
         x1 = longint'(r.rect_x) + longint'(r.rect_w) + 1;
         y1 = longint'(r.rect_y) + longint'(r.rect_h) + 1;
         px0 = a * x0 + c * y0 + e;
         py0 = b * x0 + d * y0 + f;
         px1 = a * x1 + c * y1 + e;
         py1 = b * x1 + d * y1 + f;
         xlo = bound_sat(floor_q(px0 < px1 ? px0 : px1));
         ylo = bound_sat(floor_q(py0 < py1 ? py0 : py1));
         xhi = bound_sat(ceil_q(px0 > px1 ? px0 : px1));
         yhi = bound_sat(ceil_q(py0 > py1 ? py0 : py1));
         fw = longint'(cfg.frame_width) > FRAME_LIM ? FRAME_LIM : longint'(cfg.frame_width);
         fh = longint'(cfg.frame_height) > FRAME_LIM ? FRAME_LIM : longint'(cfg.frame_height);
         res = '0;
         if (fw == 0 || fh == 0 || xhi < 0 || yhi < 0 || xlo >= fw || ylo >= fh) return res;
         ox = xlo > 0 ? xlo : 0;
         oy = ylo > 0 ? ylo : 0;
         ow = (xhi < fw ? xhi : fw) - ox;
         oh = (yhi < fh ? yhi : fh) - oy;
         res.visible    = 1'b1;
         res.out_x      = ox[COORD_BITS-1:0];
         res.out_y      = oy[COORD_BITS-1:0];
         res.out_width  = ow[SIZE_BITS-1:0];
         res.out_height = oh[SIZE_BITS-1:0];
         return res;
      endfunction

      function void note_request(req_type r);
         expected_boxes.push_back(clip_box(r));
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
         if (got !== exp) begin
            $error("%s: expected %0d, got %0d", name, exp, got);
            mismatch_count++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (expected_boxes.size() == 0) begin
            $error("result with no request outstanding");
            mismatch_count++;
            return;
         end
         exp = expected_boxes.pop_front();
         compare_field("visible", exp.visible, got.visible);
         compare_field("out_x", exp.out_x, got.out_x);
         compare_field("out_y", exp.out_y, got.out_y);
         compare_field("out_width", exp.out_width, got.out_width);
         compare_field("out_height", exp.out_height, got.out_height);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [COEF_BITS-1:0]     csr_wdata = '0;

   clip_scoreboard sb = new();
   int             idle_pct = 0;
   int             quiet_cycles = 0;

   screen_rect_to_frame_clip_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_request(req_data);
         if (rsp_valid) sb.check_result(rsp_data);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
   end

   task automatic send_rect(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
      req_type r;
      r.rect_x = x[COORD_BITS-1:0];
      r.rect_y = y[COORD_BITS-1:0];
      r.rect_w = w[SIZE_BITS-1:0];
      r.rect_h = h[SIZE_BITS-1:0];
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_boxes.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [COEF_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic apply_cfg(cfg_type c);
      logic [COEF_BITS-1:0] fw_word, fh_word;
      fw_word = $urandom;
      fh_word = $urandom;
      fw_word[SIZE_BITS-1:0] = c.frame_width;
      fh_word[SIZE_BITS-1:0] = c.frame_height;
      drain();
      write_reg(CSR_COEF_A, c.coef_a);
      write_reg(CSR_COEF_B, c.coef_b);
      write_reg(CSR_COEF_C, c.coef_c);
      write_reg(CSR_COEF_D, c.coef_d);
      write_reg(CSR_OFFSET_X, c.offset_x);
      write_reg(CSR_OFFSET_Y, c.offset_y);
      write_reg(CSR_FRAME_WIDTH, fw_word);
      write_reg(CSR_FRAME_HEIGHT, fh_word);
      csr_we <= 1'b0;
   endtask

   function automatic logic [COEF_BITS-1:0] rand_coef();
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1, 2:    return 32'h0001_0000;
         3:       return 32'hffff_0000;
         4, 5, 6: return int'($urandom_range(0, 524287)) - 262144;
         7:       return 32'h7fff_ffff;
         8:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [COEF_BITS-1:0] rand_offset();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5:
            return (int'($urandom_range(0, 32768)) - 16384) * 65536
                   + int'($urandom_range(0, 65535));
         6:       return 32'h0000_0000;
         7:       return 32'h7fff_ffff;
         8:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SIZE_BITS-1:0] rand_frame();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5, 6: return SIZE_BITS'($urandom_range(1, 16384));
         7:       return 15'd16384;
         8:       return $urandom_range(1) ? 15'd0 : 15'd1;
         default: return SIZE_BITS'($urandom_range(16385, 32767));
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.coef_a = rand_coef();
      c.coef_b = rand_coef();
      c.coef_c = rand_coef();
      c.coef_d = rand_coef();
      case ($urandom_range(3))
         0: begin
            c.coef_b = '0;
            c.coef_c = '0;
         end
         1: begin
            c.coef_a = '0;
            c.coef_d = '0;
         end
         default: ;
      endcase
      c.offset_x     = rand_offset();
      c.offset_y     = rand_offset();
      c.frame_width  = rand_frame();
      c.frame_height = rand_frame();
      return c;
   endfunction

   function automatic int unsigned rand_size();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return $urandom_range(0, 2000);
         6, 7:    return $urandom_range(0, 32767);
         8:       return 0;
         default: return 16384;
      endcase
   endfunction

   function automatic int unsigned rand_pos();
      return $urandom_range(1) ? $urandom_range(0, 16383) : $urandom_range(0, 2047);
   endfunction

   initial begin
      cfg_type c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: identity into 1920x1080
      idle_pct = 17;
      send_rect(0, 0, 0, 0);
      send_rect(100, 200, 50, 60);
      send_rect(1919, 1079, 0, 0);
      send_rect(1920, 1080, 0, 0);
      send_rect(1921, 0, 0, 0);
      send_rect(16383, 16383, 32767, 32767);
      send_rect(0, 0, 32767, 32767);
      send_rect(5000, 10, 16384, 16384);

      // mirror in x
      c = CFG_RESET;
      c.coef_a   = 32'hffff_0000;
      c.offset_x = 32'd1919 << 16;
      apply_cfg(c);
      send_rect(0, 0, 10, 10);
      send_rect(1900, 500, 100, 20);
      send_rect(3000, 5, 1, 1);

      // transpose: swap axes
      c = CFG_RESET;
      c.coef_a = '0;
      c.coef_d = '0;
      c.coef_b = 32'h0001_0000;
      c.coef_c = 32'h0001_0000;
      apply_cfg(c);
      send_rect(1500, 20, 40, 30);
      send_rect(10, 1500, 5, 5);

      // fractional scale and offsets: floor and ceiling on both signs
      c = CFG_RESET;
      c.coef_a   = 32'h0000_8000;
      c.coef_d   = 32'h0000_8000;
      c.offset_x = 32'hfffe_8000;
      c.offset_y = 32'h0000_4000;
      apply_cfg(c);
      send_rect(0, 0, 0, 0);
      send_rect(3, 3, 4, 4);
      send_rect(7, 1, 3, 9);

      // zero frame size rejects everything
      c = CFG_RESET;
      c.frame_width = '0;
      apply_cfg(c);
      send_rect(10, 10, 10, 10);
      c = CFG_RESET;
      c.frame_height = '0;
      apply_cfg(c);
      send_rect(10, 10, 10, 10);

      // frame larger than the coordinate range saturates
      c = CFG_RESET;
      c.frame_width  = 15'd32767;
      c.frame_height = 15'd16384;
      apply_cfg(c);
      send_rect(16383, 16383, 32767, 32767);
      send_rect(0, 0, 32767, 16384);

      // extreme coefficients drive the bounds into saturation
      c.coef_a   = 32'h7fff_ffff;
      c.coef_c   = 32'h7fff_ffff;
      c.coef_b   = 32'h8000_0000;
      c.coef_d   = 32'h8000_0000;
      c.offset_x = 32'h7fff_ffff;
      c.offset_y = 32'h8000_0000;
      apply_cfg(c);
      send_rect(0, 0, 0, 0);
      send_rect(16383, 16383, 32767, 32767);
      send_rect(1, 0, 0, 1);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 17 : (phase == 1) ? 66 : 0;
         for (int blk = 0; blk < 4; blk++) begin
            apply_cfg(random_cfg());
            repeat (50) send_rect(rand_pos(), rand_pos(), rand_size(), rand_size());
         end
      end

      drain();
      repeat (12) @(posedge clock);
      if (sb.expected_boxes.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_boxes.size());
         sb.mismatch_count++;
      end
      if (sb.mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
